// ===== hdl/mbe_pkg.sv =====
`timescale 1ns / 1ps

package mbe_pkg;

   localparam int MBE_FRAC_BITS = 28;
   localparam int MBE_IN_WIDTH  = 31;
   localparam int MBE_IN_FRAC   = 28;
   localparam int MBE_CNT_WIDTH = 16;
   localparam int MBE_LIMB_W    = 32;

   localparam logic [MBE_CNT_WIDTH-1:0] MBE_MAX_ITER_RESET = 16'd256;

   typedef enum logic [1:0] {
      PROD_RE_SQ = 2'd0,
      PROD_IM_SQ = 2'd1,
      PROD_CROSS = 2'd2
   } prod_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MUL    = 4'b0010,
      ST_EVAL   = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

endpackage

// ===== hdl/mbe_mul.sv =====
`timescale 1ns / 1ps

module mbe_mul
   import mbe_pkg::*;
#(
   parameter int ZW = MBE_FRAC_BITS + 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [ZW-1:0]   mag_re,
   input  logic [ZW-1:0]   mag_im,
   output logic            done,
   output logic [2*ZW-1:0] sq_re,
   output logic [2*ZW-1:0] sq_im,
   output logic [2*ZW-1:0] prod_x
);

   localparam int NL  = (ZW + MBE_LIMB_W - 1) / MBE_LIMB_W;
   localparam int PW  = NL * MBE_LIMB_W;
   localparam int LIW = (NL > 1) ? $clog2(NL) : 1;

   logic                  run_ff, run_in;
   prod_type              sel_ff, sel_in;
   logic [LIW-1:0]        li_ff, li_in;
   logic [LIW-1:0]        lj_ff, lj_in;
   logic [2*MBE_LIMB_W-1:0] mul_ff;
   logic                  tag_v_ff;
   logic                  tag_last_ff;
   prod_type              tag_sel_ff;
   logic [LIW:0]          tag_shift_ff;
   logic                  done_ff;
   logic [2*ZW-1:0]       acc_re_ff, acc_im_ff, acc_x_ff;

   logic [PW-1:0]         pad_re, pad_im, pad_a, pad_b;
   logic [MBE_LIMB_W-1:0] op_a, op_b;
   logic                  last_step;
   logic [2*PW-1:0]       part_ext;
   logic [2*PW-1:0]       part_shifted;
   logic [2*ZW-1:0]       part;

   assign pad_re = PW'(mag_re);
   assign pad_im = PW'(mag_im);

   always_comb begin
      unique case (sel_ff)
         PROD_RE_SQ: begin
            pad_a = pad_re;
            pad_b = pad_re;
         end
         PROD_IM_SQ: begin
            pad_a = pad_im;
            pad_b = pad_im;
         end
         default: begin
            pad_a = pad_re;
            pad_b = pad_im;
         end
      endcase
   end

   assign op_a = pad_a[li_ff * MBE_LIMB_W +: MBE_LIMB_W];
   assign op_b = pad_b[lj_ff * MBE_LIMB_W +: MBE_LIMB_W];

   assign last_step = (sel_ff == PROD_CROSS) && (li_ff == LIW'(NL - 1))
                      && (lj_ff == LIW'(NL - 1));

   always_comb begin
      run_in = run_ff;
      sel_in = sel_ff;
      li_in  = li_ff;
      lj_in  = lj_ff;
      if (start) begin
         run_in = 1'b1;
         sel_in = PROD_RE_SQ;
         li_in  = '0;
         lj_in  = '0;
      end else if (run_ff) begin
         if (last_step) begin
            run_in = 1'b0;
         end else if (lj_ff != LIW'(NL - 1)) begin
            lj_in = lj_ff + 1'b1;
         end else if (li_ff != LIW'(NL - 1)) begin
            lj_in = '0;
            li_in = li_ff + 1'b1;
         end else begin
            lj_in = '0;
            li_in = '0;
            sel_in = (sel_ff == PROD_RE_SQ) ? PROD_IM_SQ : PROD_CROSS;
         end
      end
   end

   assign part_ext     = (2*PW)'(mul_ff);
   assign part_shifted = part_ext << (MBE_LIMB_W * tag_shift_ff);
   assign part         = part_shifted[2*ZW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= 1'b0;
         tag_v_ff    <= 1'b0;
         tag_last_ff <= 1'b0;
         done_ff     <= 1'b0;
         sel_ff      <= PROD_RE_SQ;
         li_ff       <= '0;
         lj_ff       <= '0;
      end else begin
         run_ff      <= run_in;
         sel_ff      <= sel_in;
         li_ff       <= li_in;
         lj_ff       <= lj_in;
         tag_v_ff    <= run_ff && !start;
         tag_last_ff <= run_ff && !start && last_step;
         done_ff     <= tag_v_ff && tag_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff       <= op_a * op_b;
      tag_sel_ff   <= sel_ff;
      tag_shift_ff <= (LIW+1)'(li_ff) + (LIW+1)'(lj_ff);
      if (start) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
         acc_x_ff  <= '0;
      end else if (tag_v_ff) begin
         unique case (tag_sel_ff)
            PROD_RE_SQ: acc_re_ff <= acc_re_ff + part;
            PROD_IM_SQ: acc_im_ff <= acc_im_ff + part;
            default:    acc_x_ff  <= acc_x_ff + part;
         endcase
      end
   end

   assign done   = done_ff;
   assign sq_re  = acc_re_ff;
   assign sq_im  = acc_im_ff;
   assign prod_x = acc_x_ff;

endmodule

// ===== hdl/mandelbrot_escape_time_top.sv =====
`timescale 1ns / 1ps

// Escape-time unit for one complex point c = req_c_real + i*req_c_imag, both
// signed Q3.28. Pulse start with the point while busy is low; the item is
// taken on that edge and busy stays high until the result is out.
// Starting from z = 0 the unit repeats z = z*z + c until |z|^2 reaches 4 or
// the update count reaches csr_wr_data's limit minus one. The result appears
// for exactly one cycle with rsp_valid high: rsp_iteration_count is the
// number of updates plus one, rsp_reached_limit flags that it hit the limit.
// The receiver cannot stall the unit, so the result must be taken then.
// One shared limb multiplier forms re^2, im^2 and re*im in turn, each from
// the 32-bit limbs of the FRAC_BITS+4 bit z, with a default FRAC_BITS of 28.
// Busy is already low in the cycle that shows the result, so the next item
// can be taken on the same edge that takes the result. The limit register
// is to be written with csr_wr_en by the user only while the unit is idle;
// the block itself does not enforce this. A limit of zero acts as one.
// Reset returns the limit to 256 and leaves the unit idle with no result
// pending.

module mandelbrot_escape_time_top
   import mbe_pkg::*;
#(
   parameter int FRAC_BITS = MBE_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [MBE_IN_WIDTH-1:0] req_c_real,
   input  logic signed [MBE_IN_WIDTH-1:0] req_c_imag,
   output logic                           rsp_valid,
   output logic [MBE_CNT_WIDTH-1:0]       rsp_iteration_count,
   output logic                           rsp_reached_limit,
   input  logic                           csr_wr_en,
   input  logic [MBE_CNT_WIDTH-1:0]       csr_wr_data
);

   localparam int ZW  = FRAC_BITS + 4;
   localparam int SHL = (FRAC_BITS >= MBE_IN_FRAC) ? FRAC_BITS - MBE_IN_FRAC : 0;
   localparam int SHR = (FRAC_BITS < MBE_IN_FRAC) ? MBE_IN_FRAC - FRAC_BITS : 0;

   state_type                  state_ff, state_in;
   logic [MBE_CNT_WIDTH-1:0]   limit_ff;
   logic [MBE_CNT_WIDTH-1:0]   upd_ff;
   logic signed [ZW-1:0]       re_ff, im_ff, cr_ff, ci_ff;
   logic [2*ZW-1:0]            diff_ff, xs_ff;
   logic                       rsp_valid_ff;
   logic [MBE_CNT_WIDTH-1:0]   rsp_count_ff;
   logic                       rsp_limit_ff;

   logic signed [63:0]         cr_wide, ci_wide;
   logic [ZW-1:0]              mag_re, mag_im;
   logic                       mul_start, mul_done;
   logic [2*ZW-1:0]            sq_re, sq_im, prod_x;
   logic [2*ZW:0]              mag_sum;
   logic                       in_radius;
   logic [MBE_CNT_WIDTH-1:0]   eff_limit;
   logic [MBE_CNT_WIDTH:0]     next_count;
   logic                       go_on;
   logic                       accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   assign cr_wide = (64'(req_c_real) <<< SHL) >>> SHR;
   assign ci_wide = (64'(req_c_imag) <<< SHL) >>> SHR;

   assign mag_re = re_ff[ZW-1] ? ZW'(-re_ff) : ZW'(re_ff);
   assign mag_im = im_ff[ZW-1] ? ZW'(-im_ff) : ZW'(im_ff);

   assign mul_start = accept || (state_ff == ST_UPDATE);

   mbe_mul #(
      .ZW (ZW)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .mag_re (mag_re),
      .mag_im (mag_im),
      .done   (mul_done),
      .sq_re  (sq_re),
      .sq_im  (sq_im),
      .prod_x (prod_x)
   );

   assign mag_sum    = (2*ZW+1)'(sq_re) + (2*ZW+1)'(sq_im);
   assign in_radius  = (mag_sum[2*ZW:2*FRAC_BITS+2] == '0);
   assign eff_limit  = (limit_ff == '0) ? MBE_CNT_WIDTH'(1) : limit_ff;
   assign next_count = (MBE_CNT_WIDTH+1)'(upd_ff) + 1'b1;
   assign go_on      = in_radius && (next_count < (MBE_CNT_WIDTH+1)'(eff_limit));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = go_on ? ST_UPDATE : ST_IDLE;
         end
         ST_UPDATE: begin
            state_in = ST_MUL;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= MBE_MAX_ITER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_EVAL) && !go_on;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         re_ff  <= '0;
         im_ff  <= '0;
         upd_ff <= '0;
         cr_ff  <= cr_wide[ZW-1:0];
         ci_ff  <= ci_wide[ZW-1:0];
      end
      if (state_ff == ST_EVAL) begin
         diff_ff      <= sq_re - sq_im;
         xs_ff        <= (re_ff[ZW-1] ^ im_ff[ZW-1]) ? -prod_x : prod_x;
         rsp_count_ff <= next_count[MBE_CNT_WIDTH-1:0];
         rsp_limit_ff <= (next_count == (MBE_CNT_WIDTH+1)'(eff_limit));
      end
      if (state_ff == ST_UPDATE) begin
         re_ff  <= diff_ff[FRAC_BITS +: ZW] + cr_ff;
         im_ff  <= xs_ff[FRAC_BITS-1 +: ZW] + ci_ff;
         upd_ff <= upd_ff + 1'b1;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_iteration_count = rsp_count_ff;
   assign rsp_reached_limit   = rsp_limit_ff;

endmodule
